// File: rtl/core/sfs_pkg.sv
// Shared widths, constants, codes and controller/datapath interface types.
package sfs_pkg;

  localparam int MAX_GRID       = 64;
  localparam int MAX_FRAME_SIZE = 4096;

  localparam int POS_W      = 6;
  localparam int GRID_W     = 7;
  localparam int DUR_W      = 24;
  localparam int ACC_W      = 25;
  localparam int SIZE_W     = 13;
  localparam int ORIGIN_W   = 18;
  localparam int PROD_W     = 19;
  localparam int STEPS_W    = 25;
  localparam int TOTAL_W    = 13;
  localparam int DIVIDEND_W = 26;
  localparam int DIVISOR_W  = 24;
  localparam int DIV_STEPS  = DIVIDEND_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [ORIGIN_W-1:0] ORIGIN_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_DURATION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS           = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SINGLE_SHOT    = 3'd5;

  localparam logic FUNC_RESTART = 1'b0;

  typedef enum logic [1:0] {
    DIV_TIME,
    DIV_WRAP,
    DIV_SPLIT
  } div_sel_t;

  typedef struct packed {
    logic     capture;
    logic     restart;
    logic     div_start;
    div_sel_t div_sel;
    logic     take_time;
    logic     step;
    logic     calc_lin;
    logic     clip_lin;
    logic     take_wrap;
    logic     take_split;
    logic     load_out;
  } sfs_cmd_t;

  typedef struct packed {
    logic func;
    logic halted;
    logic steps_zero;
    logic off_grid;
    logic clip;
    logic div_done;
  } sfs_status_t;

endpackage

// File: rtl/core/sfs_divider.sv
// Shared restoring divider, one quotient bit per cycle.
module sfs_divider
  import sfs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient,
  output logic [DIVISOR_W-1:0]  remainder
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] count;
  logic [DIVISOR_W-1:0] div_q;
  logic [DIVISOR_W:0]   trial;
  logic                 fits;

  assign trial = {remainder, quotient[DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy) begin
        count <= count - DIV_CNT_W'(1);
        if (count == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      div_q     <= divisor;
    end else if (busy) begin
      quotient <= {quotient[DIVIDEND_W-2:0], fits};
      if (fits) begin
        remainder <= DIVISOR_W'(trial - {1'b0, div_q});
      end else begin
        remainder <= trial[DIVISOR_W-1:0];
      end
    end
  end

endmodule

// File: rtl/core/sfs_datapath.sv
// Datapath: config registers, time accumulator, frame position, walk and origin logic.
module sfs_datapath
  import sfs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  func,
  input  logic [DUR_W-1:0]      elapsed,
  input  sfs_cmd_t              cmd,
  output sfs_status_t           status,
  output logic [ORIGIN_W-1:0]   origin_x,
  output logic [ORIGIN_W-1:0]   origin_y,
  output logic [POS_W-1:0]      frame_column,
  output logic [POS_W-1:0]      frame_row,
  output logic                  finished
);

  logic [DUR_W-1:0]  frame_duration;
  logic [GRID_W-1:0] columns;
  logic [GRID_W-1:0] rows;
  logic [SIZE_W-1:0] frame_width;
  logic [SIZE_W-1:0] frame_height;
  logic              single_shot;

  logic [ACC_W-1:0]      acc;
  logic [POS_W-1:0]      col;
  logic [POS_W-1:0]      row;
  logic                  func_q;
  logic [DUR_W-1:0]      elapsed_q;
  logic [STEPS_W-1:0]    steps;
  logic [DIVIDEND_W-1:0] lin;
  logic [TOTAL_W-1:0]    total;

  logic [GRID_W-1:0] nc;
  logic [GRID_W-1:0] nr;
  logic [DUR_W-1:0]  dur;
  logic [SIZE_W-1:0] fw;
  logic [SIZE_W-1:0] fh;

  logic              at_last;
  logic [GRID_W-1:0] col_inc;
  logic [GRID_W-1:0] row_inc;
  logic [POS_W-1:0]  col_step;
  logic [POS_W-1:0]  row_step;
  logic              last_after_step;
  logic [ACC_W-1:0]  acc_sum;
  logic [TOTAL_W-1:0] row_base;
  logic [2*GRID_W-1:0] grid_prod;
  logic [DIVIDEND_W-1:0] lin_next;
  logic [PROD_W-1:0] prod_x;
  logic [PROD_W-1:0] prod_y;

  logic                  div_done;
  logic [DIVIDEND_W-1:0] dividend;
  logic [DIVISOR_W-1:0]  divisor;
  logic [DIVIDEND_W-1:0] quotient;
  logic [DIVISOR_W-1:0]  remainder;

  // Effective register values after clamping.
  assign nc  = (columns == '0) ? GRID_W'(1) :
               (columns > GRID_W'(MAX_GRID)) ? GRID_W'(MAX_GRID) : columns;
  assign nr  = (rows == '0) ? GRID_W'(1) :
               (rows > GRID_W'(MAX_GRID)) ? GRID_W'(MAX_GRID) : rows;
  assign dur = (frame_duration == '0) ? DUR_W'(1) : frame_duration;
  assign fw  = (frame_width > SIZE_W'(MAX_FRAME_SIZE)) ? SIZE_W'(MAX_FRAME_SIZE) : frame_width;
  assign fh  = (frame_height > SIZE_W'(MAX_FRAME_SIZE)) ? SIZE_W'(MAX_FRAME_SIZE) : frame_height;

  assign at_last = ({1'b0, col} == nc - GRID_W'(1)) && ({1'b0, row} == nr - GRID_W'(1));

  // Single frame step, used only while the position is off the grid.
  assign col_inc = {1'b0, col} + GRID_W'(1);
  assign row_inc = {1'b0, row} + GRID_W'(1);

  always_comb begin
    if (col_inc >= nc) begin
      col_step = '0;
      row_step = (row_inc >= nr) ? '0 : row_inc[POS_W-1:0];
    end else begin
      col_step = col_inc[POS_W-1:0];
      row_step = row;
    end
  end

  assign last_after_step = ({1'b0, col_step} == nc - GRID_W'(1)) &&
                           ({1'b0, row_step} == nr - GRID_W'(1));

  assign acc_sum   = acc + ACC_W'(elapsed_q);
  assign row_base  = TOTAL_W'(row) * TOTAL_W'(nc);
  assign grid_prod = nc * nr;
  assign lin_next  = DIVIDEND_W'(row_base) + DIVIDEND_W'(col) + DIVIDEND_W'(steps);

  always_comb begin
    unique case (cmd.div_sel)
      DIV_TIME: begin
        dividend = DIVIDEND_W'(acc_sum);
        divisor  = dur;
      end
      DIV_WRAP: begin
        dividend = lin;
        divisor  = DIVISOR_W'(total);
      end
      DIV_SPLIT: begin
        dividend = lin;
        divisor  = DIVISOR_W'(nc);
      end
      default: begin
        dividend = lin;
        divisor  = DIVISOR_W'(nc);
      end
    endcase
  end

  sfs_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (dividend),
    .divisor   (divisor),
    .done      (div_done),
    .quotient  (quotient),
    .remainder (remainder)
  );

  assign prod_x = PROD_W'(col) * PROD_W'(fw);
  assign prod_y = PROD_W'(row) * PROD_W'(fh);

  assign status.func       = func_q;
  assign status.halted     = single_shot && at_last;
  assign status.steps_zero = (steps == '0);
  assign status.off_grid   = ({1'b0, col} >= nc) || ({1'b0, row} >= nr);
  assign status.clip       = single_shot && (lin >= DIVIDEND_W'(total) - DIVIDEND_W'(1));
  assign status.div_done   = div_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_duration <= DUR_W'(1);
      columns        <= GRID_W'(1);
      rows           <= GRID_W'(1);
      frame_width    <= SIZE_W'(1);
      frame_height   <= SIZE_W'(1);
      single_shot    <= 1'b0;
      acc            <= '0;
      col            <= '0;
      row            <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_FRAME_DURATION: frame_duration <= cfg_data[DUR_W-1:0];
          REG_COLUMNS:        columns        <= cfg_data[GRID_W-1:0];
          REG_ROWS:           rows           <= cfg_data[GRID_W-1:0];
          REG_FRAME_WIDTH:    frame_width    <= cfg_data[SIZE_W-1:0];
          REG_FRAME_HEIGHT:   frame_height   <= cfg_data[SIZE_W-1:0];
          REG_SINGLE_SHOT:    single_shot    <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.restart) begin
        acc <= '0;
        col <= '0;
        row <= '0;
      end
      if (cmd.take_time) begin
        acc <= ACC_W'(remainder);
      end
      if (cmd.step) begin
        col <= col_step;
        row <= row_step;
        if (single_shot && last_after_step) begin
          acc <= '0;
        end
      end
      if (cmd.clip_lin) begin
        acc <= '0;
      end
      if (cmd.take_split) begin
        row <= quotient[POS_W-1:0];
        col <= remainder[POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_q    <= func;
      elapsed_q <= elapsed;
    end
    if (cmd.take_time) begin
      steps <= quotient[STEPS_W-1:0];
    end
    if (cmd.step) begin
      // reaching the last frame in single-shot drops the remaining steps
      steps <= (single_shot && last_after_step) ? '0 : steps - STEPS_W'(1);
    end
    if (cmd.calc_lin) begin
      lin   <= lin_next;
      total <= grid_prod[TOTAL_W-1:0];
    end
    if (cmd.clip_lin) begin
      lin <= DIVIDEND_W'(total) - DIVIDEND_W'(1);
    end
    if (cmd.take_wrap) begin
      lin <= DIVIDEND_W'(remainder);
    end
    if (cmd.load_out) begin
      origin_x     <= (prod_x > PROD_W'(ORIGIN_MAX)) ? ORIGIN_MAX : prod_x[ORIGIN_W-1:0];
      origin_y     <= (prod_y > PROD_W'(ORIGIN_MAX)) ? ORIGIN_MAX : prod_y[ORIGIN_W-1:0];
      frame_column <= col;
      frame_row    <= row;
      finished     <= single_shot && at_last;
    end
  end

endmodule

// File: rtl/core/sfs_ctrl.sv
// Controller: sequences accept, time division, frame walk, wrap, split and result beat.
module sfs_ctrl
  import sfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  sfs_status_t status,
  output sfs_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_DIV_TIME,
    S_WALK,
    S_WRAP,
    S_DIV_WRAP,
    S_SPLIT,
    S_DIV_SPLIT,
    S_ORIGIN
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd        = '0;
    cmd.div_sel = DIV_TIME;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (status.func == FUNC_RESTART) begin
          cmd.restart = 1'b1;
          state_next  = S_ORIGIN;
        end else if (status.halted) begin
          state_next = S_ORIGIN;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_TIME;
          state_next    = S_DIV_TIME;
        end
      end
      S_DIV_TIME: begin
        if (status.div_done) begin
          cmd.take_time = 1'b1;
          state_next    = S_WALK;
        end
      end
      S_WALK: begin
        if (status.steps_zero) begin
          state_next = S_ORIGIN;
        end else if (status.off_grid) begin
          cmd.step = 1'b1;
        end else begin
          cmd.calc_lin = 1'b1;
          state_next   = S_WRAP;
        end
      end
      S_WRAP: begin
        if (status.clip) begin
          cmd.clip_lin = 1'b1;
          state_next   = S_SPLIT;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_WRAP;
          state_next    = S_DIV_WRAP;
        end
      end
      S_DIV_WRAP: begin
        if (status.div_done) begin
          cmd.take_wrap = 1'b1;
          state_next    = S_SPLIT;
        end
      end
      S_SPLIT: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_SPLIT;
        state_next    = S_DIV_SPLIT;
      end
      S_DIV_SPLIT: begin
        if (status.div_done) begin
          cmd.take_split = 1'b1;
          state_next     = S_ORIGIN;
        end
      end
      S_ORIGIN: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/core/sprite_frame_sequencer.sv
// Sprite-sheet animation sequencer top level: controller, datapath and checks.
// One item is worked at a time; in_stall is high from the accepting edge until the result
// is loaded into the output register. A restart uses no division. An advance uses only the
// time division when no frame wrap is needed past it, and up to three divisions when the
// position is moved along the grid, all on the shared divider (one quotient bit per cycle).
// If a register change left the position off the grid, the walk first steps one frame per
// cycle back onto it. Every item yields exactly one result beat; a new item may be accepted
// while that beat still waits on out_stall.
module sprite_frame_sequencer
  import sfs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  func,
  input  logic [DUR_W-1:0]      elapsed,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [ORIGIN_W-1:0]   origin_x,
  output logic [ORIGIN_W-1:0]   origin_y,
  output logic [POS_W-1:0]      frame_column,
  output logic [POS_W-1:0]      frame_row,
  output logic                  finished
);

  sfs_cmd_t    cmd;
  sfs_status_t status;

  sfs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  sfs_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .func         (func),
    .elapsed      (elapsed),
    .cmd          (cmd),
    .status       (status),
    .origin_x     (origin_x),
    .origin_y     (origin_y),
    .frame_column (frame_column),
    .frame_row    (frame_row),
    .finished     (finished)
  );

  // an accepted beat always occupies the block for at least the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while block still idle after previous accept");

  // the block only goes idle again by loading a result
  a_idle_has_result: assert property (@(posedge clk) disable iff (rst)
    $fell(in_stall) |-> out_valid)
    else $error("block went idle without a pending result");

  // a fresh result comes only from a busy block
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall) && !in_stall)
    else $error("result appeared without work in progress");

endmodule
